// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expands to one labeled
// concurrent assertion that is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- src/tcgr_pkg.sv -----
package tcgr_pkg;

	localparam int CELL_WIDTH = 8;
	localparam int RAW_AW     = 14;

	typedef enum logic [2:0] {
		REG_VIDEO_FLAGS      = 3'd0,
		REG_CHAR_HEIGHT      = 3'd1,
		REG_SECONDARY_LOADED = 3'd2,
		REG_CURSOR_FIRST_ROW = 3'd3,
		REG_CURSOR_LAST_ROW  = 3'd4,
		REG_CURSOR_VISIBLE   = 3'd5,
		REG_CURSOR_BLINK     = 3'd6,
		REG_CURSOR_COLOR     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0] video_flags;
		logic [4:0] char_height;
		logic       secondary_loaded;
		logic [7:0] cursor_first_row;
		logic [3:0] cursor_last_row;
		logic       cursor_visible;
		logic       cursor_blink;
		logic [3:0] cursor_color;
	} cfg_t;

	// What the output stage needs to finish a render word.
	typedef struct packed {
		logic       use_secondary;
		logic       fill;
		logic [3:0] fill_color;
		logic [3:0] fg;
		logic [3:0] bg;
	} render_meta_t;

	function automatic logic [4*CELL_WIDTH-1:0] fill_row(input logic [3:0] color);
		logic [4*CELL_WIDTH-1:0] r;
		r = '0;
		for (int x = 0; x < CELL_WIDTH; x++) begin
			r[4*x +: 4] = color;
		end
		return r;
	endfunction

endpackage

// ----- src/tcgr_glyph_ram.sv -----
module tcgr_glyph_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while the pipeline stage behind it is stalled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/tcgr_cell_decode.sv -----
module tcgr_cell_decode #(
	parameter int GLYPH_STORE_DEPTH = 4096,
	parameter int MAX_CHAR_HEIGHT   = 16,
	parameter int AW                = 12
) (
	input  logic                  mode,
	input  logic [11:0]           font_address,
	input  logic [15:0]           cell_word,
	input  logic [3:0]            glyph_row,
	input  logic                  blink_phase,
	input  logic                  cursor_here,
	input  tcgr_pkg::cfg_t        cfg,
	output logic [AW-1:0]         addr,
	output tcgr_pkg::render_meta_t meta
);
	import tcgr_pkg::*;

	localparam logic [5:0] MAXH = 6'(MAX_CHAR_HEIGHT);
	localparam int NSUB = (255 * MAX_CHAR_HEIGHT + 15) / GLYPH_STORE_DEPTH + 1;
	localparam logic [RAW_AW-1:0] DEPTH_W = RAW_AW'(GLYPH_STORE_DEPTH);

	logic [4:0]        height;
	logic [RAW_AW-1:0] raw;
	logic [RAW_AW-1:0] wrapped;
	logic [3:0]        fg_raw;
	logic [3:0]        bg;
	logic              row_out;
	logic              cursor_on;

	always_comb begin
		height = ({1'b0, cfg.char_height} > MAXH) ? MAXH[4:0] : cfg.char_height;
	end

	// Loads and renders share one address path and one wrap chain.
	always_comb begin
		if (mode) begin
			raw = RAW_AW'(cell_word[7:0]) * RAW_AW'(height) + RAW_AW'(glyph_row);
		end else begin
			raw = RAW_AW'(font_address);
		end
		wrapped = raw;
		for (int i = 0; i < NSUB; i++) begin
			if (wrapped >= DEPTH_W) begin
				wrapped = wrapped - DEPTH_W;
			end
		end
		addr = wrapped[AW-1:0];
	end

	always_comb begin
		if (cfg.video_flags[0]) begin
			bg     = cell_word[15:12];
			fg_raw = cell_word[11:8];
		end else begin
			bg = {1'b0, cell_word[14:12]};
			if (cell_word[15] && blink_phase) begin
				fg_raw = bg;
			end else begin
				fg_raw = cell_word[11:8];
			end
		end
		row_out   = {1'b0, glyph_row} >= height;
		cursor_on = cfg.cursor_visible && cursor_here
			&& (blink_phase || !cfg.cursor_blink)
			&& (cfg.cursor_first_row <= {4'd0, cfg.cursor_last_row})
			&& ({4'd0, glyph_row} >= cfg.cursor_first_row)
			&& (glyph_row <= cfg.cursor_last_row);

		meta.use_secondary = cfg.video_flags[2] && fg_raw[3] && cfg.secondary_loaded;
		meta.fg            = cfg.video_flags[1] ? {1'b0, fg_raw[2:0]} : fg_raw;
		meta.bg            = bg;
		meta.fill          = row_out || cursor_on;
		meta.fill_color    = row_out ? bg : cfg.cursor_color;
	end

endmodule

// ----- src/tcgr_pixel_out.sv -----
module tcgr_pixel_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tcgr_pkg::render_meta_t meta,
	input  logic [7:0]             glyph,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata   // pixel_row[31:0]
);
	import tcgr_pkg::*;

	logic [31:0] row_d;
	logic [31:0] row_q;
	logic        valid_q;

	// Bit 7 of the glyph byte is the leftmost pixel, which lands in bits 3..0.
	always_comb begin
		if (meta.fill) begin
			row_d = fill_row(meta.fill_color);
		end else begin
			row_d = '0;
			for (int x = 0; x < CELL_WIDTH; x++) begin
				row_d[4*x +: 4] = glyph[CELL_WIDTH-1-x] ? meta.fg : meta.bg;
			end
		end
	end

	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			row_q <= row_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = row_q;

endmodule

// ----- src/text_cell_glyph_renderer_top.sv -----
// Path: a render word's glyph byte is read into stage 1 at its acceptance edge, and
// the pixel row is then registered in the output register before it is offered.
// Throughput: one word per cycle unless the output stalls; renders read both stores.
// Load words write the glyph store at acceptance and produce no output.
// Reset clears the configuration registers to their defaults and empties the
// pipeline; the glyph stores are not cleared and hold garbage until loaded.
`include "assert_macros.svh"

module text_cell_glyph_renderer_top #(
	parameter int GLYPH_STORE_DEPTH = 4096,
	parameter int MAX_CHAR_HEIGHT   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// font_address[11:0], font_data[19:12], cell_word[35:20], glyph_row[39:36],
	// blink_phase[40], cursor_here[41], zero pad[47:42]
	input  logic [47:0] s_tdata,
	// mode[0], font_select[1]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_row[31:0]
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tcgr_pkg::*;

	localparam int AW = $clog2(GLYPH_STORE_DEPTH);

	cfg_t         cfg_q;
	logic         s_acc;
	logic         render_acc;
	logic         load_acc;
	logic [AW-1:0] addr;
	render_meta_t meta_d;
	render_meta_t meta_s1;
	logic         valid_s1;
	logic         out_ready;
	logic [7:0]   pri_rdata;
	logic [7:0]   sec_rdata;
	logic [7:0]   glyph_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.video_flags      <= 3'd0;
			cfg_q.char_height      <= 5'd16;
			cfg_q.secondary_loaded <= 1'b0;
			cfg_q.cursor_first_row <= 8'd0;
			cfg_q.cursor_last_row  <= 4'd15;
			cfg_q.cursor_visible   <= 1'b0;
			cfg_q.cursor_blink     <= 1'b0;
			cfg_q.cursor_color     <= 4'd7;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VIDEO_FLAGS:      cfg_q.video_flags      <= cfg_data[2:0];
				REG_CHAR_HEIGHT:      cfg_q.char_height      <= cfg_data[4:0];
				REG_SECONDARY_LOADED: cfg_q.secondary_loaded <= cfg_data[0];
				REG_CURSOR_FIRST_ROW: cfg_q.cursor_first_row <= cfg_data;
				REG_CURSOR_LAST_ROW:  cfg_q.cursor_last_row  <= cfg_data[3:0];
				REG_CURSOR_VISIBLE:   cfg_q.cursor_visible   <= cfg_data[0];
				REG_CURSOR_BLINK:     cfg_q.cursor_blink     <= cfg_data[0];
				REG_CURSOR_COLOR:     cfg_q.cursor_color     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Stage 1 takes a new word whenever it is empty or moving into the output register.
	assign s_tready   = !valid_s1 || out_ready;
	assign s_acc      = s_tvalid && s_tready;
	assign render_acc = s_acc && s_tuser[0];
	assign load_acc   = s_acc && !s_tuser[0];

	tcgr_cell_decode #(
		.GLYPH_STORE_DEPTH(GLYPH_STORE_DEPTH),
		.MAX_CHAR_HEIGHT  (MAX_CHAR_HEIGHT),
		.AW               (AW)
	) u_decode (
		.mode        (s_tuser[0]),
		.font_address(s_tdata[11:0]),
		.cell_word   (s_tdata[35:20]),
		.glyph_row   (s_tdata[39:36]),
		.blink_phase (s_tdata[40]),
		.cursor_here (s_tdata[41]),
		.cfg         (cfg_q),
		.addr        (addr),
		.meta        (meta_d)
	);

	// Loads and renders are applied in acceptance order, so a render always
	// sees every earlier load without forwarding.
	tcgr_glyph_ram #(
		.DEPTH(GLYPH_STORE_DEPTH),
		.AW   (AW)
	) u_primary (
		.clk  (clk),
		.we   (load_acc && !s_tuser[1]),
		.waddr(addr),
		.wdata(s_tdata[19:12]),
		.re   (render_acc),
		.raddr(addr),
		.rdata(pri_rdata)
	);

	tcgr_glyph_ram #(
		.DEPTH(GLYPH_STORE_DEPTH),
		.AW   (AW)
	) u_secondary (
		.clk  (clk),
		.we   (load_acc && s_tuser[1]),
		.waddr(addr),
		.wdata(s_tdata[19:12]),
		.re   (render_acc),
		.raddr(addr),
		.rdata(sec_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= render_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (render_acc) begin
			meta_s1 <= meta_d;
		end
	end

	assign glyph_s1 = meta_s1.use_secondary ? sec_rdata : pri_rdata;

	tcgr_pixel_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s1),
		.in_ready(out_ready),
		.meta    (meta_s1),
		.glyph   (glyph_s1),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	`ASSERT_NEXT(a_s1_holds_when_blocked, clk, arst_n, valid_s1 && !out_ready, valid_s1)
	`ASSERT_NEXT(a_load_leaves_s1_empty, clk, arst_n, load_acc, !valid_s1)
	`ASSERT_IMPL(a_stall_means_full, clk, arst_n, !s_tready, valid_s1 && m_tvalid)

endmodule
